@@ hdl/ppe_pkg.sv @@
// Shared types and constants of the page table populate engine.
package ppe_pkg;

   // Sizes fixed by the four-level x86-64 layout.
   localparam int TABLE_PAGES_DEF   = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;
   localparam int VPAGE_W           = 36;
   localparam int FRAME_W           = 40;
   localparam int SLOT_CNT_W        = 7;
   localparam int SLOT_EXT_W        = 12;
   localparam int LEAF_W            = 52;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 64;

   // Register reset values and entry flag bits (present and writable).
   localparam logic [FRAME_W-1:0]    POOL_BASE_RESET  = 40'd256;
   localparam logic [SLOT_CNT_W-1:0] POOL_PAGES_RESET = 7'd64;
   localparam logic [11:0]           ENTRY_FLAGS      = 12'h003;
   localparam logic [1:0]            LEVEL_LAST       = 2'd2;

   // Request and response payloads.
   typedef struct packed {
      logic [VPAGE_W-1:0] virt_page;
      logic [FRAME_W-1:0] phys_frame;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [1:0]            new_tables;
      logic [SLOT_CNT_W-1:0] tables_in_use;
      logic                  failure_seen;
      logic [LEAF_W-1:0]     leaf_entry;
   } rsp_type;

   // One stored table entry: present bit and the frame it points to.
   typedef struct packed {
      logic               present;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   // Memory port controls from the walker.
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LEAF,
      ST_DONE
   } walk_state_type;

   // Register select is address bit 3 (registers at byte 0 and byte 8).
   typedef enum logic {
      REG_POOL_BASE  = 1'b0,
      REG_POOL_PAGES = 1'b1
   } reg_sel_type;

   // Table index of an upper level taken from the virtual page number.
   function automatic logic [IDX_W-1:0] level_index(input logic [VPAGE_W-1:0] vp,
                                                    input logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = vp[35:27];
         2'd1:    idx = vp[26:18];
         default: idx = vp[17:9];
      endcase
      return idx;
   endfunction

endpackage

@@ hdl/ppe_store.sv @@
// Table store: one synchronous single-port memory of table entries.
module ppe_store
   import ppe_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF,
   localparam int SW         = $clog2(TABLE_PAGES),
   localparam int AW         = SW + IDX_W,
   localparam int DEPTH      = TABLE_PAGES * ENTRIES_PER_TABLE
) (
   input  logic        clock,
   input  mem_ctl_type mem_ctl,
   input  logic [AW-1:0] mem_addr,
   input  entry_type   mem_wdata,
   output entry_type   mem_rdata
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rd_data_ff;

endmodule

@@ hdl/ppe_csr.sv @@
// Configuration registers: pool base frame and pool size.
module ppe_csr
   import ppe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [FRAME_W-1:0]    pool_base,
   output logic [SLOT_CNT_W-1:0] pool_pages
);

   logic [FRAME_W-1:0]    pool_base_ff, pool_base_in;
   logic [SLOT_CNT_W-1:0] pool_pages_ff, pool_pages_in;
   logic                  wr_en;
   reg_sel_type           sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign sel        = reg_sel_type'(csr_paddr[3]);

   // Write decode.
   always_comb begin
      pool_base_in  = pool_base_ff;
      pool_pages_in = pool_pages_ff;
      if (wr_en) begin
         unique case (sel)
            REG_POOL_BASE:  pool_base_in  = csr_pwdata[FRAME_W-1:0];
            REG_POOL_PAGES: pool_pages_in = csr_pwdata[SLOT_CNT_W-1:0];
            default:        pool_base_in  = pool_base_ff;
         endcase
      end
   end

   // Read decode.
   always_comb begin
      unique case (sel)
         REG_POOL_BASE:  csr_prdata = CSR_DATA_W'(pool_base_ff);
         REG_POOL_PAGES: csr_prdata = CSR_DATA_W'(pool_pages_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= POOL_BASE_RESET;
         pool_pages_ff <= POOL_PAGES_RESET;
      end else begin
         pool_base_ff  <= pool_base_in;
         pool_pages_ff <= pool_pages_in;
      end
   end

   assign pool_base  = pool_base_ff;
   assign pool_pages = pool_pages_ff;

endmodule

@@ hdl/ppe_walker.sv @@
// Table walker: sequencer that reads, allocates and writes table entries.
module ppe_walker
   import ppe_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF,
   localparam int SW         = $clog2(TABLE_PAGES),
   localparam int AW         = SW + IDX_W,
   localparam int DEPTH      = TABLE_PAGES * ENTRIES_PER_TABLE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic [FRAME_W-1:0]    pool_base,
   input  logic [SLOT_CNT_W-1:0] pool_pages,
   output mem_ctl_type           mem_ctl,
   output logic [AW-1:0]         mem_addr,
   output entry_type             mem_wdata,
   input  entry_type             mem_rdata
);

   walk_state_type state_ff, state_in;

   logic [AW-1:0]         clr_ff, clr_in;
   logic [SLOT_CNT_W-1:0] nfs_ff, nfs_in;
   logic                  failed_ff, failed_in;
   logic [1:0]            lvl_ff, lvl_in;
   logic [SLOT_CNT_W-1:0] slot_ff, slot_in;
   logic [1:0]            made_ff, made_in;
   logic                  ok_ff, ok_in;
   logic [VPAGE_W-1:0]    vp_ff, vp_in;
   logic [FRAME_W-1:0]    pf_ff, pf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_take;
   logic                  rsp_load;
   logic                  clr_last;
   logic [FRAME_W-1:0]    rel;
   logic                  link_bad;
   logic                  pool_empty;
   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [IDX_W-1:0]      cur_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign clr_last  = (clr_ff == AW'(DEPTH - 1));

   // Link check on a present entry and the allocator limit.
   assign rel        = mem_rdata.frame - pool_base;
   assign link_bad   = (rel >= FRAME_W'(nfs_ff)) || (rel >= FRAME_W'(TABLE_PAGES));
   assign pool_empty = (nfs_ff >= pool_pages) || (32'(nfs_ff) >= 32'(TABLE_PAGES));

   assign slot_ext = SLOT_EXT_W'(slot_ff);
   assign cur_idx  = level_index(vp_ff, lvl_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_take) state_in = ST_READ;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL: begin
            if (mem_rdata.present) begin
               if (link_bad)                  state_in = ST_DONE;
               else if (lvl_ff == LEVEL_LAST) state_in = ST_LEAF;
               else                           state_in = ST_READ;
            end else begin
               if (pool_empty)                state_in = ST_DONE;
               else if (lvl_ff == LEVEL_LAST) state_in = ST_LEAF;
               else                           state_in = ST_READ;
            end
         end
         ST_LEAF:  state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in    = clr_ff;
      nfs_in    = nfs_ff;
      failed_in = failed_ff;
      lvl_in    = lvl_ff;
      slot_in   = slot_ff;
      made_in   = made_ff;
      ok_in     = ok_ff;
      vp_in     = vp_ff;
      pf_in     = pf_ff;
      mem_ctl   = '0;
      mem_addr  = {slot_ext[SW-1:0], cur_idx};
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero every entry once after reset.
            mem_ctl.wr = 1'b1;
            mem_addr   = clr_ff;
            clr_in     = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               vp_in   = req_data.virt_page;
               pf_in   = req_data.phys_frame;
               lvl_in  = '0;
               slot_in = '0;
               made_in = '0;
               ok_in   = 1'b0;
            end
         end
         ST_READ: begin
            mem_ctl.rd = 1'b1;
         end
         ST_EVAL: begin
            if (mem_rdata.present) begin
               // Follow the existing link.
               slot_in = rel[SLOT_CNT_W-1:0];
               lvl_in  = lvl_ff + 2'd1;
            end else if (pool_empty) begin
               failed_in = 1'b1;
            end else begin
               // Take a fresh page and link it at the same entry.
               mem_ctl.wr      = 1'b1;
               mem_wdata.present = 1'b1;
               mem_wdata.frame = pool_base + FRAME_W'(nfs_ff);
               slot_in         = nfs_ff;
               nfs_in          = nfs_ff + SLOT_CNT_W'(1);
               made_in         = made_ff + 2'd1;
               lvl_in          = lvl_ff + 2'd1;
            end
         end
         ST_LEAF: begin
            mem_ctl.wr        = 1'b1;
            mem_addr          = {slot_ext[SW-1:0], vp_ff[IDX_W-1:0]};
            mem_wdata.present = 1'b1;
            mem_wdata.frame   = pf_ff;
            ok_in             = 1'b1;
         end
         ST_DONE: begin
            clr_in = clr_ff;
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // Output register: a finished request waits here while the walker moves on.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.ok            = ok_ff;
         rsp_in.new_tables    = made_ff;
         rsp_in.tables_in_use = nfs_ff;
         rsp_in.failure_seen  = failed_ff;
         rsp_in.leaf_entry    = ok_ff ? {pf_ff, ENTRY_FLAGS} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nfs_ff       <= SLOT_CNT_W'(1);
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nfs_ff       <= nfs_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      slot_ff <= slot_in;
      made_ff <= made_in;
      ok_ff   <= ok_in;
      vp_ff   <= vp_in;
      pf_ff   <= pf_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/page_table_populate_engine.sv @@
// Sequence: after a request is accepted, the walker reads and then evaluates one entry per
// upper level, writes the leaf entry and loads the result register once it is free; a request
// that stops at the first, second or third level goes to the result load without the leaf
// write. No new request is taken until the result is loaded, as the walk is sequential on the
// single-port table store. Reset: synchronous; afterwards a clearing pass zeroes the store
// and no request is taken until it ends. Configuration writes are taken throughout.
module page_table_populate_engine
   import ppe_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(TABLE_PAGES) + IDX_W;

   logic [FRAME_W-1:0]    pool_base;
   logic [SLOT_CNT_W-1:0] pool_pages;
   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         mem_addr;
   entry_type             mem_wdata;
   entry_type             mem_rdata;

   // Configuration registers.
   ppe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pool_base   (pool_base),
      .pool_pages  (pool_pages)
   );

   // Walk sequencer and result register.
   ppe_walker #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .pool_base  (pool_base),
      .pool_pages (pool_pages),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   // Table page store.
   ppe_store #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

@@ verif/page_table_populate_engine_tb.sv @@
// Self-checking testbench for the page table populate engine.
`timescale 1ns / 100ps

module page_table_populate_engine_tb;
   import ppe_pkg::*;

   localparam int PAGES          = TABLE_PAGES_DEF;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_RUN  = 242;
   localparam int TAIL_CYCLES    = 30;
   localparam int CYCLE_LIMIT    = 1_000_000;

   typedef enum logic {ROW_MAP, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {WALK_OK, WALK_NO_PAGES, WALK_BAD_LINK} walk_status_type;

   // One line of the directed script: either a map request or a register write.
   typedef struct {
      row_kind_type kind;
      req_type      req;
      bit           pinned;
      rsp_type      want;
      reg_sel_type  sel;
      logic [63:0]  value;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the table store, the allocator and the two registers.
   logic [63:0]        mirror_store [PAGES*ENTRIES_PER_TABLE];
   int unsigned        mirror_next_slot;
   logic               mirror_failed;
   logic [FRAME_W-1:0] mirror_base;
   logic [6:0]         mirror_pages;

   rsp_type        due_results [$];
   logic [26:0]    known_prefix [$];
   script_row_type directed_rows [$];
   bit             pinned_now = 1'b0;
   rsp_type        pinned_value = '0;
   rsp_type        head_result;
   rsp_type        head_predicted;
   bit             steady = 1'b0;
   int             fail_count = 0;
   int             cycle_count = 0;
   logic [6:0]         phase_pool [PHASES];
   logic [FRAME_W-1:0] phase_base [PHASES];

   page_table_populate_engine #(.TABLE_PAGES(PAGES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Follow or create one upper-level entry; a new page is cleared before it is linked.
   function automatic walk_status_type walk_level(input int unsigned slot,
                                                  input logic [IDX_W-1:0] idx,
                                                  output int unsigned child,
                                                  inout int unsigned made);
      int unsigned        pos;
      int unsigned        fresh;
      int unsigned        ceiling;
      logic [63:0]        entry;
      logic [FRAME_W-1:0] rel;
      logic [FRAME_W-1:0] frame;
      child = 0;
      pos = slot * ENTRIES_PER_TABLE + idx;
      entry = mirror_store[pos];
      if (entry[0]) begin
         // The link must name a slot already handed out under the current base.
         rel = entry[51:12] - mirror_base;
         if (rel >= mirror_next_slot || rel >= PAGES) return WALK_BAD_LINK;
         child = rel[31:0];
         return WALK_OK;
      end
      ceiling = (mirror_pages > PAGES) ? PAGES : mirror_pages;
      if (mirror_next_slot >= ceiling) begin
         mirror_failed = 1'b1;
         return WALK_NO_PAGES;
      end
      fresh = mirror_next_slot;
      for (int i = 0; i < ENTRIES_PER_TABLE; i++) mirror_store[fresh*ENTRIES_PER_TABLE + i] = '0;
      frame = mirror_base + FRAME_W'(fresh);
      mirror_next_slot = fresh + 1;
      mirror_store[pos] = {12'h000, frame, ENTRY_FLAGS};
      child = fresh;
      made++;
      return WALK_OK;
   endfunction

   // Walk the three upper levels, then write the leaf entry when the walk got through.
   function automatic rsp_type map_page(input req_type r);
      rsp_type          res;
      logic [IDX_W-1:0] lvl_idx [3];
      int unsigned      slot;
      int unsigned      child;
      int unsigned      made;
      walk_status_type  status;
      logic [LEAF_W-1:0] leaf;
      lvl_idx[0] = r.virt_page[35:27];
      lvl_idx[1] = r.virt_page[26:18];
      lvl_idx[2] = r.virt_page[17:9];
      slot = 0;
      made = 0;
      status = WALK_OK;
      leaf = '0;
      for (int lvl = 0; lvl < 3 && status == WALK_OK; lvl++) begin
         status = walk_level(slot, lvl_idx[lvl], child, made);
         if (status == WALK_OK) slot = child;
      end
      if (status == WALK_OK) begin
         leaf = {r.phys_frame, ENTRY_FLAGS};
         mirror_store[slot*ENTRIES_PER_TABLE + r.virt_page[8:0]] = {12'h000, leaf};
      end
      res.ok            = (status == WALK_OK);
      res.new_tables    = made[1:0];
      res.tables_in_use = mirror_next_slot[6:0];
      res.failure_seen  = mirror_failed;
      res.leaf_entry    = leaf;
      return res;
   endfunction

   // Random map request: mostly pages under tables already built, some new branches.
   function automatic req_type pick_request();
      req_type     r;
      logic [63:0] noise;
      logic [63:0] frame_bits;
      logic [26:0] prefix;
      logic [26:0] seen;
      int          roll;
      int          frame_roll;
      noise = {$urandom(), $urandom()};
      frame_bits = {$urandom(), $urandom()};
      roll = $urandom_range(0, 99);
      frame_roll = $urandom_range(0, 19);
      prefix = noise[62:36];
      if (known_prefix.size() != 0 && roll < 80) begin
         seen = known_prefix[$urandom_range(0, known_prefix.size() - 1)];
         if (roll < 55) prefix = seen;
         else if (roll < 70) prefix = {seen[26:9], noise[44:36]};
         else prefix = {seen[26:18], noise[53:36]};
      end
      known_prefix.push_back(prefix);
      r.virt_page = {prefix, noise[8:0]};
      if (frame_roll == 0) r.phys_frame = '0;
      else if (frame_roll == 1) r.phys_frame = '1;
      else r.phys_frame = frame_bits[FRAME_W-1:0];
      return r;
   endfunction

   function automatic void add_map(input logic [VPAGE_W-1:0] vp, input logic [FRAME_W-1:0] pf,
                                   input bit pin, input rsp_type want);
      script_row_type row;
      row.kind = ROW_MAP;
      row.req.virt_page = vp;
      row.req.phys_frame = pf;
      row.pinned = pin;
      row.want = want;
      row.sel = REG_POOL_BASE;
      row.value = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_cfg(input reg_sel_type sel, input logic [63:0] value);
      script_row_type row;
      row.kind = ROW_CFG;
      row.req = '0;
      row.pinned = 1'b0;
      row.want = '0;
      row.sel = sel;
      row.value = value;
      directed_rows.push_back(row);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Present one request, with an occasional gap before it, and hold it until taken.
   task automatic send_request(input req_type r, input bit pin, input rsp_type want);
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data     <= r;
      pinned_now   <= pin;
      pinned_value <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending and wait until every outstanding request has its result.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic csr_write(input reg_sel_type sel, input logic [63:0] value);
      logic [63:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_POOL_BASE) mirror_base = value[FRAME_W-1:0];
      else mirror_pages = value[6:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == REG_POOL_BASE) check_field("pool_base_frame", mirror_base, got[FRAME_W-1:0]);
      else check_field("pool_pages", mirror_pages, got[6:0]);
   endtask

   // The receiver stalls at random about 7 percent of the time, except during the steady phase.
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(0, 99) >= 7);

   // Compare each result with the oldest expectation and predict each accepted request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("Result %h arrived with no request outstanding", rsp_data);
               fail_count++;
            end else begin
               head_result = due_results.pop_front();
               check_field("ok", head_result.ok, rsp_data.ok);
               check_field("new_tables", head_result.new_tables, rsp_data.new_tables);
               check_field("tables_in_use", head_result.tables_in_use, rsp_data.tables_in_use);
               check_field("failure_seen", head_result.failure_seen, rsp_data.failure_seen);
               check_field("leaf_entry", head_result.leaf_entry, rsp_data.leaf_entry);
            end
         end
         if (req_valid && req_ready) begin
            head_predicted = map_page(req_data);
            due_results.push_back(pinned_now ? pinned_value : head_predicted);
         end
      end
   end

   // Watchdog on the whole run, the clearing pass after reset included.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      req_type item;
      for (int i = 0; i < PAGES*ENTRIES_PER_TABLE; i++) mirror_store[i] = '0;
      mirror_next_slot = 1;
      mirror_failed    = 1'b0;
      mirror_base      = POOL_BASE_RESET;
      mirror_pages     = POOL_PAGES_RESET;
      phase_pool = '{7'd28, 7'd36, 7'd44, 7'd48, 7'd56, 7'd64, 7'd64, 7'd127};
      phase_base = '{40'd256, 40'd256, 40'd256, 40'hFF_FFFF_FFF0,
                     40'd256, 40'd256, 40'd256, 40'd256};

      // A fresh path needs all three upper tables; the same path again needs none.
      add_map(36'h0, 40'h0, 1'b1, {1'b1, 2'd3, 7'd4, 1'b0, 52'h3});
      add_map(36'h0, 40'hFF_FFFF_FFFF, 1'b1, {1'b1, 2'd0, 7'd4, 1'b0, 40'hFF_FFFF_FFFF, 12'h003});
      add_map(36'hF_FFFF_FFFF, 40'h12_3456_789A, 1'b1,
              {1'b1, 2'd3, 7'd7, 1'b0, 40'h12_3456_789A, 12'h003});
      // A new leaf in an existing table, then branches that split at the lowest, middle and top level.
      add_map(36'h0_0000_01FF, 40'h00_0000_0001, 1'b0, '0);
      add_map(36'h0_0000_0200, 40'h80_0000_0000, 1'b0, '0);
      add_map(36'h0_0004_0000, 40'h55_AA55_AA55, 1'b0, '0);
      add_map(36'h0_0800_0000, 40'hAB_CDEF_0123, 1'b0, '0);
      // Moving the pool base strands the old links; new pages get wrapped frames.
      add_cfg(REG_POOL_BASE, 64'hFF_FFFF_FFFF);
      add_map(36'h0, 40'h11_2233_4455, 1'b1, {1'b0, 2'd0, 7'd13, 1'b0, 52'h0});
      add_map(36'h0_1000_0000, 40'h66_7788_99AA, 1'b0, '0);
      add_map(36'h0_1000_01A5, 40'h0F_0F0F_0F0F, 1'b0, '0);
      add_cfg(REG_POOL_BASE, 64'h0);
      add_map(36'h0_1000_0000, 40'h33_3333_3333, 1'b0, '0);
      add_cfg(REG_POOL_BASE, 64'd256);
      add_map(36'h0, 40'h7F_FFFF_FFFE, 1'b0, '0);
      // Running out of pages partway through a walk keeps the tables already linked.
      add_cfg(REG_POOL_PAGES, 64'd17);
      add_map(36'h0_1800_0000, 40'h01_0203_0405, 1'b1, {1'b0, 2'd1, 7'd17, 1'b1, 52'h0});
      add_map(36'h0_1800_0000, 40'h01_0203_0405, 1'b1, {1'b0, 2'd0, 7'd17, 1'b1, 52'h0});
      // A pool of one page or none allows nothing beyond the root.
      add_cfg(REG_POOL_PAGES, 64'd1);
      add_map(36'h0_2000_0000, 40'h22_2222_2222, 1'b1, {1'b0, 2'd0, 7'd17, 1'b1, 52'h0});
      add_cfg(REG_POOL_PAGES, 64'd0);
      add_map(36'h0_2000_0000, 40'h22_2222_2222, 1'b1, {1'b0, 2'd0, 7'd17, 1'b1, 52'h0});
      add_cfg(REG_POOL_PAGES, 64'd64);
      add_map(36'h0_2000_0000, 40'h0, 1'b1, {1'b1, 2'd3, 7'd20, 1'b1, 52'h3});
      add_map(36'h0_1800_0123, 40'hC0_FFEE_0001, 1'b0, '0);

      // Synchronous reset, then the directed script.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            settle();
            csr_write(directed_rows[i].sel, directed_rows[i].value);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
         end
      end

      // Random phases, each setting a pool size and base; the pool never shrinks as the run goes on.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         csr_write(REG_POOL_BASE, 64'(phase_base[p]));
         csr_write(REG_POOL_PAGES, 64'(phase_pool[p]));
         steady = (p == PHASES - 2);
         for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            item = pick_request();
            send_request(item, 1'b0, '0);
         end
      end
      steady = 1'b0;

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
